// ===== hw/rtl/at_rsm_pkg.sv =====
// ----------------------------------------------------------------------------
// AT response stream matcher package
// Shared request codes, phase type, character constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package at_rsm_pkg;

    // Request codes carried by an input item.
    typedef enum logic [1:0] {
        REQ_BYTE     = 2'd0,
        REQ_ARM_ACK  = 2'd1,
        REQ_ARM_RESP = 2'd2
    } t_req;

    // Phase of the server response matcher.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_CAPTURE = 2'd2
    } t_phase;

    // One item as it leaves the input register.
    typedef struct packed {
        logic       fire;
        t_req       req;
        logic [7:0] ch;
    } t_step;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ACK_PATTERN = 2'd0;
    localparam logic [1:0] CFG_ACK_LENGTH  = 2'd1;

    // Configuration reset values ("ok", two characters).
    localparam logic [63:0] ACK_PATTERN_RST = 64'h0000_0000_0000_6B6F;
    localparam logic [3:0]  ACK_LENGTH_RST  = 4'd2;
    localparam logic [3:0]  MAX_PATTERN     = 4'd8;

    // Character constants.
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CASE_BIT     = 8'h20;
    localparam logic [2:0] HDR_LEN      = 3'd5;
    localparam logic [2:0] TRL_LEN      = 3'd6;

    // Output field widths.
    localparam int POS_W  = 10;
    localparam int MARK_W = 11;

    // Folds upper-case letters to lower case.
    function automatic logic [7:0] fold_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c >= 8'h41) && (c <= 8'h5A)) begin
            r = c | CASE_BIT;
        end
        return r;
    endfunction

    // Characters of the response header "+ipd,".
    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0: r = 8'h2B;
            3'd1: r = 8'h69;
            3'd2: r = 8'h70;
            3'd3: r = 8'h64;
            3'd4: r = 8'h2C;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Characters of the response trailer CR LF "ok" CR LF.
    function automatic logic [7:0] trl_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0: r = CH_CR;
            3'd1: r = CH_LF;
            3'd2: r = 8'h6F;
            3'd3: r = 8'h6B;
            3'd4: r = CH_CR;
            3'd5: r = CH_LF;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/at_rsm_ack.sv =====
// ----------------------------------------------------------------------------
// Acknowledge matcher
// Armable matcher for the configured acknowledge pattern of up to 8 characters.
// ----------------------------------------------------------------------------
`default_nettype none

module at_rsm_ack
    import at_rsm_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_step  i_step,
    input  wire  [63:0] i_pattern,
    input  wire  [3:0]  i_pattern_len,
    output logic        o_ack_found
);

    logic [3:0] r_pos;
    logic       r_looking;
    logic       r_seen;
    logic [3:0] n_pos;
    logic       n_looking;
    logic       n_seen;
    logic [3:0] len;
    logic [3:0] pos_inc;
    logic [7:0] pat_char;

    // Effective pattern length, clamped to one .. MAX_PATTERN.
    always_comb begin
        len = i_pattern_len;
        if (len == 4'd0) begin
            len = 4'd1;
        end else if (len > MAX_PATTERN) begin
            len = MAX_PATTERN;
        end
    end

    assign pat_char = i_pattern[{r_pos[2:0], 3'b000} +: 8];
    assign pos_inc  = r_pos + 4'd1;

    // Arm, advance on a matching character or restart on a mismatch.
    always_comb begin
        n_pos     = r_pos;
        n_looking = r_looking;
        n_seen    = r_seen;
        if (i_step.fire) begin
            case (i_step.req)
                REQ_ARM_ACK: begin
                    n_pos     = 4'd0;
                    n_seen    = 1'b0;
                    n_looking = 1'b1;
                end
                REQ_BYTE: begin
                    if (r_looking) begin
                        if (pat_char == i_step.ch) begin
                            n_pos = pos_inc;
                            if (pos_inc >= len) begin
                                n_seen    = 1'b1;
                                n_looking = 1'b0;
                            end
                        end else begin
                            n_pos = 4'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 4'd0;
            r_looking <= 1'b0;
            r_seen    <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_looking <= n_looking;
            r_seen    <= n_seen;
        end
    end

    assign o_ack_found = n_seen;

endmodule

`default_nettype wire

// ===== hw/rtl/at_rsm_resp.sv =====
// ----------------------------------------------------------------------------
// Server response matcher
// Waits for the header, then captures folded characters until the trailer.
// ----------------------------------------------------------------------------
`default_nettype none

module at_rsm_resp
    import at_rsm_pkg::*;
#(
    parameter int CAPTURE_DEPTH = 1024
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire t_step         i_step,
    output t_phase             o_phase,
    output logic               o_done,
    output logic               o_capture_valid,
    output logic [POS_W-1:0]   o_capture_position,
    output logic [7:0]         o_capture_char
);

    localparam int CNT_W = $clog2(CAPTURE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    t_phase           r_state;
    t_phase           n_state;
    logic [2:0]       r_pos;
    logic [2:0]       n_pos;
    logic             r_finished;
    logic             n_finished;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             room;
    logic [EXT_W-1:0] count_ext;

    assign room      = (r_count < CNT_W'(CAPTURE_DEPTH));
    assign count_ext = EXT_W'(r_count);

    // Next state: header search, then capture and trailer search.
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_finished = r_finished;
        n_count    = r_count;
        if (i_step.fire) begin
            case (i_step.req)
                REQ_ARM_RESP: begin
                    n_pos      = 3'd0;
                    n_state    = PH_HEADER;
                    n_finished = 1'b0;
                    n_count    = '0;
                end
                REQ_BYTE: begin
                    case (r_state)
                        PH_HEADER: begin
                            if ((r_pos < HDR_LEN) && (hdr_char(r_pos) == i_step.ch)) begin
                                n_pos = r_pos + 3'd1;
                                if (n_pos >= HDR_LEN) begin
                                    n_state = PH_CAPTURE;
                                    n_pos   = 3'd0;
                                end
                            end else begin
                                n_pos = 3'd0;
                            end
                        end
                        PH_CAPTURE: begin
                            if (room) begin
                                n_count = r_count + CNT_W'(1);
                            end
                            if ((r_pos < TRL_LEN) && (trl_char(r_pos) == i_step.ch)) begin
                                n_pos = r_pos + 3'd1;
                                if (n_pos >= TRL_LEN) begin
                                    n_finished = 1'b1;
                                    n_state    = PH_IDLE;
                                    n_pos      = 3'd0;
                                end
                            end else begin
                                n_pos = 3'd0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Capture outputs for the current item.
    always_comb begin
        o_capture_valid    = 1'b0;
        o_capture_position = '0;
        o_capture_char     = 8'h00;
        if (i_step.fire && (i_step.req == REQ_BYTE) && (r_state == PH_CAPTURE) && room) begin
            o_capture_valid    = 1'b1;
            o_capture_position = count_ext[POS_W-1:0];
            o_capture_char     = i_step.ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= PH_IDLE;
            r_pos      <= 3'd0;
            r_finished <= 1'b0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_finished <= n_finished;
            r_count    <= n_count;
        end
    end

    assign o_phase = n_state;
    assign o_done  = n_finished;

endmodule

`default_nettype wire

// ===== hw/rtl/at_rsm_ring.sv =====
// ----------------------------------------------------------------------------
// Receive ring tracker
// Keeps the ring write index and the marks taken at line ends.
// ----------------------------------------------------------------------------
`default_nettype none

module at_rsm_ring
    import at_rsm_pkg::*;
#(
    parameter int RING_DEPTH = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire t_step          i_step,
    output logic                o_byte_stored,
    output logic [POS_W-1:0]    o_ring_position,
    output logic                o_line_end,
    output logic [MARK_W-1:0]   o_previous_line_mark,
    output logic [MARK_W-1:0]   o_latest_line_mark
);

    localparam int IDX_W = $clog2(RING_DEPTH + 1);
    localparam int EXT_W = (IDX_W > MARK_W) ? IDX_W : MARK_W;

    logic [IDX_W-1:0] r_wr_idx;
    logic [IDX_W-1:0] n_wr_idx;
    logic [IDX_W-1:0] r_older;
    logic [IDX_W-1:0] n_older;
    logic [IDX_W-1:0] r_newer;
    logic [IDX_W-1:0] n_newer;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] base_inc;
    logic             is_byte;
    logic             is_eol;
    logic [EXT_W-1:0] base_ext;
    logic [EXT_W-1:0] older_ext;
    logic [EXT_W-1:0] newer_ext;

    // A full ring wraps to slot zero before the write.
    assign base     = (r_wr_idx >= IDX_W'(RING_DEPTH)) ? '0 : r_wr_idx;
    assign base_inc = base + IDX_W'(1);
    assign is_byte  = i_step.fire && (i_step.req == REQ_BYTE);
    assign is_eol   = is_byte && ((i_step.ch == CH_CR) || (i_step.ch == CH_LF));

    // Advance the write index; a line end records it and restarts at zero.
    always_comb begin
        n_wr_idx = r_wr_idx;
        n_older  = r_older;
        n_newer  = r_newer;
        if (is_byte) begin
            n_wr_idx = base_inc;
            if (is_eol) begin
                n_older  = r_newer;
                n_newer  = base_inc;
                n_wr_idx = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_older  <= '0;
            r_newer  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_older  <= n_older;
            r_newer  <= n_newer;
        end
    end

    assign base_ext  = EXT_W'(base);
    assign older_ext = EXT_W'(n_older);
    assign newer_ext = EXT_W'(n_newer);

    assign o_byte_stored        = is_byte;
    assign o_ring_position      = is_byte ? base_ext[POS_W-1:0] : '0;
    assign o_line_end           = is_eol;
    assign o_previous_line_mark = older_ext[MARK_W-1:0];
    assign o_latest_line_mark   = newer_ext[MARK_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/at_response_stream_matcher_unit.sv =====
// ----------------------------------------------------------------------------
// AT response stream matcher
// Path: an accepted input item waits in the input register, then passes the
// matcher logic into the result register once that register is free.
// Throughput: one item per cycle while results are taken; the input register,
// the single pass of matcher logic and the result register set that figure.
// Reset: synchronous, active low; clears all matcher state and restores the
// acknowledge pattern "ok" of length two. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_stream_matcher_unit
    import at_rsm_pkg::*;
#(
    parameter int RING_DEPTH    = 1024,
    parameter int CAPTURE_DEPTH = 1024
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // Input item channel
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [1:0]          i_req_type,
    input  wire  [7:0]          i_rx_byte,
    // Result item channel
    output logic                o_valid,
    input  wire                 i_stall,
    output logic                o_ack_found,
    output logic [1:0]          o_response_phase,
    output logic                o_response_done,
    output logic                o_byte_stored,
    output logic [POS_W-1:0]    o_ring_position,
    output logic                o_capture_valid,
    output logic [POS_W-1:0]    o_capture_position,
    output logic [7:0]          o_capture_char,
    output logic                o_line_end,
    output logic [MARK_W-1:0]   o_previous_line_mark,
    output logic [MARK_W-1:0]   o_latest_line_mark,
    // Configuration write channel
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [1:0]          i_cfg_index,
    input  wire  [63:0]         i_cfg_data
);

    logic        r_in_valid;
    t_req        r_req;
    logic [7:0]  r_rx_byte;
    logic        r_out_valid;
    logic [63:0] r_ack_pattern;
    logic [3:0]  r_ack_length;
    logic        advance;
    logic        load_in;
    t_step       step;

    logic                ack_found;
    t_phase              phase;
    logic                done;
    logic                cap_valid;
    logic [POS_W-1:0]    cap_pos;
    logic [7:0]          cap_char;
    logic                stored;
    logic [POS_W-1:0]    ring_pos;
    logic                line_end;
    logic [MARK_W-1:0]   prev_mark;
    logic [MARK_W-1:0]   last_mark;

    logic                r_ack_found;
    logic [1:0]          r_phase;
    logic                r_done;
    logic                r_cap_valid;
    logic [POS_W-1:0]    r_cap_pos;
    logic [7:0]          r_cap_char;
    logic                r_stored;
    logic [POS_W-1:0]    r_ring_pos;
    logic                r_line_end;
    logic [MARK_W-1:0]   r_prev_mark;
    logic [MARK_W-1:0]   r_last_mark;

    // Flow control: the result register frees when empty or taken.
    assign advance = !r_out_valid || !i_stall;
    assign load_in = !r_in_valid || advance;
    assign o_stall = !load_in;

    // Configuration registers, written whenever the port offers a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_pattern <= ACK_PATTERN_RST;
            r_ack_length  <= ACK_LENGTH_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ACK_PATTERN: r_ack_pattern <= i_cfg_data;
                CFG_ACK_LENGTH:  r_ack_length  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load_in) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in && i_valid) begin
            r_req     <= t_req'(i_req_type);
            r_rx_byte <= i_rx_byte;
        end
    end

    // The registered item enters the matchers when the result register frees.
    assign step.fire = r_in_valid && advance;
    assign step.req  = r_req;
    assign step.ch   = fold_char(r_rx_byte);

    at_rsm_ack u_ack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_pattern     (r_ack_pattern),
        .i_pattern_len (r_ack_length),
        .o_ack_found   (ack_found)
    );

    at_rsm_resp #(
        .CAPTURE_DEPTH (CAPTURE_DEPTH)
    ) u_resp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_step             (step),
        .o_phase            (phase),
        .o_done             (done),
        .o_capture_valid    (cap_valid),
        .o_capture_position (cap_pos),
        .o_capture_char     (cap_char)
    );

    at_rsm_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_step               (step),
        .o_byte_stored        (stored),
        .o_ring_position      (ring_pos),
        .o_line_end           (line_end),
        .o_previous_line_mark (prev_mark),
        .o_latest_line_mark   (last_mark)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.fire) begin
            r_ack_found <= ack_found;
            r_phase     <= phase;
            r_done      <= done;
            r_cap_valid <= cap_valid;
            r_cap_pos   <= cap_pos;
            r_cap_char  <= cap_char;
            r_stored    <= stored;
            r_ring_pos  <= ring_pos;
            r_line_end  <= line_end;
            r_prev_mark <= prev_mark;
            r_last_mark <= last_mark;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_ack_found          = r_ack_found;
    assign o_response_phase     = r_phase;
    assign o_response_done      = r_done;
    assign o_byte_stored        = r_stored;
    assign o_ring_position      = r_ring_pos;
    assign o_capture_valid      = r_cap_valid;
    assign o_capture_position   = r_cap_pos;
    assign o_capture_char       = r_cap_char;
    assign o_line_end           = r_line_end;
    assign o_previous_line_mark = r_prev_mark;
    assign o_latest_line_mark   = r_last_mark;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AT response stream matcher testbench
// Offers received bytes and arm requests through the valid/stall channel
// with bursty input and a changing output stall pattern. A behavioural
// model of both matchers, the ring index and the line marks predicts the
// status of every item, and each returned item is compared field by field.
// A directed table comes first, then well-formed and broken exchanges under
// several acknowledge pattern settings, including a capture store overflow.
// ----------------------------------------------------------------------------

module tb_top
    import at_rsm_pkg::*;
();

    localparam int RING_SLOTS    = 1024;
    localparam int CAPTURE_SLOTS = 1024;
    localparam int CYCLE_LIMIT   = 300000;

    // Request and register codes that the package leaves unnamed.
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    // Fixed texts, first character in the most significant byte.
    localparam logic [47:0] HEADER_TEXT  = {8'h00, "+ipd,"};
    localparam logic [47:0] TRAILER_TEXT = {CH_CR, CH_LF, "ok", CH_CR, CH_LF};

    // Status carried by one result item, in port order.
    typedef struct packed {
        logic              ack_found;
        logic [1:0]        phase;
        logic              done;
        logic              stored;
        logic [POS_W-1:0]  ring_pos;
        logic              cap;
        logic [POS_W-1:0]  cap_pos;
        logic [7:0]        cap_char;
        logic              line_end;
        logic [MARK_W-1:0] prev_mark;
        logic [MARK_W-1:0] latest_mark;
    } t_status;

    // One row of the directed table.
    typedef struct packed {
        logic [1:0] req;
        logic [7:0] ch;
        logic       fixed;
        t_status    want;
    } t_row;

    // Output stall patterns.
    typedef enum int {
        FLOW_FREE,
        FLOW_LIGHT,
        FLOW_PERIODIC,
        FLOW_HEAVY
    } t_flow;

    localparam t_status ALL_CLEAR = '0;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [1:0]  i_req_type  = REQ_BYTE;
    logic [7:0]  i_rx_byte   = 8'h00;
    logic        i_stall     = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = CFG_ACK_PATTERN;
    logic [63:0] i_cfg_data  = 64'd0;

    wire              o_stall;
    wire              o_valid;
    wire              o_ack_found;
    wire [1:0]        o_response_phase;
    wire              o_response_done;
    wire              o_byte_stored;
    wire [POS_W-1:0]  o_ring_position;
    wire              o_capture_valid;
    wire [POS_W-1:0]  o_capture_position;
    wire [7:0]        o_capture_char;
    wire              o_line_end;
    wire [MARK_W-1:0] o_previous_line_mark;
    wire [MARK_W-1:0] o_latest_line_mark;
    wire              o_cfg_ready;

    // Typed-in expectation that travels with the item on offer.
    logic    item_fixed = 1'b0;
    t_status item_want  = ALL_CLEAR;

    // Model state, mirrored from the block's reset values.
    int unsigned ring_wr    = 0;
    int unsigned mark_old   = 0;
    int unsigned mark_new   = 0;
    logic [3:0]  ack_pos    = 4'd0;
    logic        ack_armed  = 1'b0;
    logic        ack_hit    = 1'b0;
    t_phase      resp_phase = PH_IDLE;
    int          resp_pos   = 0;
    logic        resp_done  = 1'b0;
    int unsigned cap_count  = 0;
    logic [63:0] cfg_pattern = ACK_PATTERN_RST;
    logic [3:0]  cfg_length  = ACK_LENGTH_RST;

    t_status pending_status[$];
    t_row    dir_rows[$];
    int      mismatches   = 0;
    int      results_seen = 0;
    int      items_sent   = 0;
    int      burst_left   = 1;
    int      cycles       = 0;
    t_flow   stall_mode   = FLOW_FREE;
    int      stall_hold   = 0;

    at_response_stream_matcher_unit #(
        .RING_DEPTH    (RING_SLOTS),
        .CAPTURE_DEPTH (CAPTURE_SLOTS)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_req_type           (i_req_type),
        .i_rx_byte            (i_rx_byte),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_ack_found          (o_ack_found),
        .o_response_phase     (o_response_phase),
        .o_response_done      (o_response_done),
        .o_byte_stored        (o_byte_stored),
        .o_ring_position      (o_ring_position),
        .o_capture_valid      (o_capture_valid),
        .o_capture_position   (o_capture_position),
        .o_capture_char       (o_capture_char),
        .o_line_end           (o_line_end),
        .o_previous_line_mark (o_previous_line_mark),
        .o_latest_line_mark   (o_latest_line_mark),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Character i of a text held with its first character most significant.
    function automatic logic [7:0] text_char(input logic [47:0] text, input int len,
                                             input int i);
        return text[8*(len-1-i) +: 8];
    endfunction

    function automatic logic [7:0] lower_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z") begin
            return c | CASE_BIT;
        end
        return c;
    endfunction

    // Pattern length as the matcher uses it: clamped to one..MAX_PATTERN.
    function automatic int unsigned ack_span();
        int unsigned n;
        n = 32'(cfg_length);
        if (n == 0) n = 1;
        if (n > MAX_PATTERN) n = 32'(MAX_PATTERN);
        return n;
    endfunction

    // Advances the model by one item and returns the status it shows.
    function automatic t_status next_status(input logic [1:0] req, input logic [7:0] raw);
        t_status    r;
        logic [7:0] c;
        r = ALL_CLEAR;
        c = lower_case(raw);
        case (req)
            REQ_ARM_ACK: begin
                ack_pos   = 4'd0;
                ack_hit   = 1'b0;
                ack_armed = 1'b1;
            end
            REQ_ARM_RESP: begin
                resp_pos   = 0;
                resp_phase = PH_HEADER;
                resp_done  = 1'b0;
                cap_count  = 0;
            end
            REQ_BYTE: begin
                if (ring_wr >= RING_SLOTS) ring_wr = 0;
                r.stored   = 1'b1;
                r.ring_pos = ring_wr[POS_W-1:0];
                ring_wr++;

                // Acknowledge search; a mismatch restarts without a retry.
                if (ack_armed) begin
                    if (cfg_pattern[8*ack_pos[2:0] +: 8] == c) begin
                        ack_pos = ack_pos + 4'd1;
                        if (ack_pos >= ack_span()) begin
                            ack_hit   = 1'b1;
                            ack_armed = 1'b0;
                        end
                    end else begin
                        ack_pos = 4'd0;
                    end
                end

                // Server response: header first, then capture until the trailer.
                if (resp_phase == PH_HEADER) begin
                    if (resp_pos < HDR_LEN &&
                        text_char(HEADER_TEXT, int'(HDR_LEN), resp_pos) == c) begin
                        resp_pos++;
                        if (resp_pos >= HDR_LEN) begin
                            resp_phase = PH_CAPTURE;
                            resp_pos   = 0;
                        end
                    end else begin
                        resp_pos = 0;
                    end
                end else if (resp_phase == PH_CAPTURE) begin
                    if (cap_count < CAPTURE_SLOTS) begin
                        r.cap      = 1'b1;
                        r.cap_pos  = cap_count[POS_W-1:0];
                        r.cap_char = c;
                        cap_count++;
                    end
                    if (resp_pos < TRL_LEN &&
                        text_char(TRAILER_TEXT, int'(TRL_LEN), resp_pos) == c) begin
                        resp_pos++;
                        if (resp_pos >= TRL_LEN) begin
                            resp_done  = 1'b1;
                            resp_phase = PH_IDLE;
                            resp_pos   = 0;
                        end
                    end else begin
                        resp_pos = 0;
                    end
                end

                // A line end records the next ring index and restarts the ring.
                if (raw == CH_CR || raw == CH_LF) begin
                    r.line_end = 1'b1;
                    mark_old   = mark_new;
                    mark_new   = ring_wr;
                    ring_wr    = 0;
                end
            end
            default: begin
            end
        endcase
        r.ack_found   = ack_hit;
        r.phase       = resp_phase;
        r.done        = resp_done;
        r.prev_mark   = mark_old[MARK_W-1:0];
        r.latest_mark = mark_new[MARK_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        $display("mismatch at result %0d: %s expected %0h got %0h",
                 results_seen, what, want, got);
    endtask

    task automatic check_status();
        t_status seen;
        t_status want;
        seen = {o_ack_found, o_response_phase, o_response_done, o_byte_stored,
                o_ring_position, o_capture_valid, o_capture_position, o_capture_char,
                o_line_end, o_previous_line_mark, o_latest_line_mark};
        if (pending_status.size() == 0) begin
            flag_mismatch("result item with nothing expected", 64'd0, 64'(seen));
        end else begin
            want = pending_status.pop_front();
            if (seen.ack_found !== want.ack_found)
                flag_mismatch("ack_found", 64'(want.ack_found), 64'(seen.ack_found));
            if (seen.phase !== want.phase)
                flag_mismatch("response_phase", 64'(want.phase), 64'(seen.phase));
            if (seen.done !== want.done)
                flag_mismatch("response_done", 64'(want.done), 64'(seen.done));
            if (seen.stored !== want.stored)
                flag_mismatch("byte_stored", 64'(want.stored), 64'(seen.stored));
            if (seen.ring_pos !== want.ring_pos)
                flag_mismatch("ring_position", 64'(want.ring_pos), 64'(seen.ring_pos));
            if (seen.cap !== want.cap)
                flag_mismatch("capture_valid", 64'(want.cap), 64'(seen.cap));
            if (seen.cap_pos !== want.cap_pos)
                flag_mismatch("capture_position", 64'(want.cap_pos), 64'(seen.cap_pos));
            if (seen.cap_char !== want.cap_char)
                flag_mismatch("capture_char", 64'(want.cap_char), 64'(seen.cap_char));
            if (seen.line_end !== want.line_end)
                flag_mismatch("line_end", 64'(want.line_end), 64'(seen.line_end));
            if (seen.prev_mark !== want.prev_mark)
                flag_mismatch("previous_line_mark", 64'(want.prev_mark),
                              64'(seen.prev_mark));
            if (seen.latest_mark !== want.latest_mark)
                flag_mismatch("latest_line_mark", 64'(want.latest_mark),
                              64'(seen.latest_mark));
        end
        results_seen++;
    endtask

    // Handshake monitor: results are checked before this edge's item is
    // predicted, as no item can return in the cycle it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                check_status();
            end
            if (i_valid && !o_stall) begin
                if (item_fixed) begin
                    void'(next_status(i_req_type, i_rx_byte));
                    pending_status.push_back(item_want);
                end else begin
                    pending_status.push_back(next_status(i_req_type, i_rx_byte));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ACK_PATTERN: cfg_pattern = i_cfg_data;
                    CFG_ACK_LENGTH:  cfg_length  = i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Output stall: a pattern chosen at random and renewed when its hold count runs out.
    always @(negedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode = t_flow'($urandom_range(0, 3));
            stall_hold = $urandom_range(30, 200);
        end else begin
            stall_hold--;
        end
        case (stall_mode)
            FLOW_FREE:     i_stall <= 1'b0;
            FLOW_LIGHT:    i_stall <= ($urandom_range(0, 99) < 30);
            FLOW_PERIODIC: i_stall <= ((cycles % 7) < 3);
            default:       i_stall <= ($urandom_range(0, 99) < 75);
        endcase
    end

    // Offers one item and holds it until taken; the sender pauses between bursts.
    task automatic offer(input logic [1:0] req, input logic [7:0] ch, input logic fixed,
                         input t_status want);
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_rx_byte  <= ch;
        item_fixed <= fixed;
        item_want  <= want;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        if (req != REQ_UNUSED) items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            i_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(10, 30)) @(negedge i_clk);
            else repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic send_byte(input logic [7:0] ch);
        offer(REQ_BYTE, ch, 1'b0, ALL_CLEAR);
    endtask

    // Requests other than a byte carry a random, ignored byte.
    task automatic send_req(input logic [1:0] req);
        offer(req, 8'($urandom_range(0, 255)), 1'b0, ALL_CLEAR);
    endtask

    function automatic logic [7:0] mixed_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
            return c & ~CASE_BIT;
        end
        return c;
    endfunction

    // Random byte with line ends made common.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0:       return CH_CR;
            1:       return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [63:0] letter_pattern();
        logic [63:0] p;
        for (int i = 0; i < 8; i++) begin
            p[8*i +: 8] = 8'($urandom_range(8'h61, 8'h7A));
        end
        return p;
    endfunction

    // Sends a text in random letter case, now and then with a character spoilt.
    task automatic send_text(input logic [47:0] text, input int len, input bit spoil);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            c = text_char(text, len, i);
            if (spoil && $urandom_range(0, 11) == 0) c = noise_byte();
            send_byte(mixed_case(c));
        end
    endtask

    task automatic ack_exchange();
        int unsigned span;
        logic [7:0]  c;
        span = ack_span();
        send_req(REQ_ARM_ACK);
        repeat ($urandom_range(0, 2)) send_byte(noise_byte());
        for (int i = 0; i < span; i++) begin
            c = cfg_pattern[8*i +: 8];
            if ($urandom_range(0, 9) == 0) c = noise_byte();
            send_byte(mixed_case(c));
        end
        repeat ($urandom_range(0, 3)) send_byte(noise_byte());
    endtask

    task automatic server_response(input int body_max);
        send_req(REQ_ARM_RESP);
        repeat ($urandom_range(0, 2)) send_byte(noise_byte());
        send_text(HEADER_TEXT, int'(HDR_LEN), 1'b1);
        repeat ($urandom_range(0, body_max)) send_byte(noise_byte());
        send_text(TRAILER_TEXT, int'(TRL_LEN), 1'b1);
    endtask

    task automatic play_random(input int count);
        int first;
        first = items_sent;
        while (items_sent - first < count) begin
            case ($urandom_range(0, 9))
                0, 1, 2: ack_exchange();
                3, 4, 5: server_response(24);
                6:       repeat ($urandom_range(1, 10)) send_byte(noise_byte());
                7:       send_req(REQ_UNUSED);
                8: begin
                    send_byte(CH_CR);
                    send_byte(CH_LF);
                end
                default: send_req($urandom_range(0, 1) ? REQ_ARM_ACK : REQ_ARM_RESP);
            endcase
        end
    endtask

    // Stops offering and waits until every result has come back.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_status.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_ack(input logic [63:0] pattern, input logic [3:0] length);
        settle();
        write_reg(CFG_ACK_PATTERN, pattern);
        write_reg(CFG_ACK_LENGTH, 64'(length));
    endtask

    initial begin
        logic [7:0] c;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table; rows with fixed = 1 carry their expected status.
        // Straight after reset nothing is armed: a byte is only stored.
        dir_rows.push_back({REQ_BYTE, "A", 1'b1, {1'b0, PH_IDLE, 1'b0, 1'b1, 10'd0,
                            1'b0, 10'd0, 8'd0, 1'b0, 11'd0, 11'd0}});
        // An unknown request changes nothing.
        dir_rows.push_back({REQ_UNUSED, 8'hFF, 1'b1, ALL_CLEAR});
        dir_rows.push_back({REQ_ARM_ACK, 8'h00, 1'b1, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "O", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "K", 1'b0, ALL_CLEAR});
        // Carriage return at ring slot 3 marks index 4 and restarts the ring.
        dir_rows.push_back({REQ_BYTE, CH_CR, 1'b1, {1'b1, PH_IDLE, 1'b0, 1'b1, 10'd3,
                            1'b0, 10'd0, 8'd0, 1'b1, 11'd0, 11'd4}});
        // Rearm, then "ook": the second 'o' restarts the search and 'k' misses.
        dir_rows.push_back({REQ_ARM_ACK, 8'h00, 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "o", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "o", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "k", 1'b0, ALL_CLEAR});
        // Full server response with extreme byte values in the body.
        dir_rows.push_back({REQ_ARM_RESP, 8'hFF, 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "+", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "I", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "P", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "D", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, ",", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "x", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, 8'h00, 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, 8'hFF, 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, CH_CR, 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, CH_LF, 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "O", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, "K", 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, CH_CR, 1'b0, ALL_CLEAR});
        dir_rows.push_back({REQ_BYTE, CH_LF, 1'b0, ALL_CLEAR});
        foreach (dir_rows[k]) begin
            offer(dir_rows[k].req, dir_rows[k].ch, dir_rows[k].fixed, dir_rows[k].want);
        end
        settle();

        play_random(300);

        // A length of zero behaves as a single character.
        set_ack(letter_pattern(), 4'd0);
        play_random(120);

        // A body longer than both the ring and the capture store, free of line ends.
        send_req(REQ_ARM_RESP);
        send_text(HEADER_TEXT, int'(HDR_LEN), 1'b0);
        repeat (1040) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_CR || c == CH_LF) c = "z";
            send_byte(c);
        end
        send_text(TRAILER_TEXT, int'(TRL_LEN), 1'b0);

        // Eight characters; shortening the length mid-search ends it on the next hit.
        set_ack(64'h6867_6665_6463_6261, 4'd8);
        send_req(REQ_ARM_ACK);
        send_text(48'("abcd"), 4, 1'b0);
        settle();
        write_reg(CFG_ACK_LENGTH, 64'd2);
        send_byte("e");

        // Length field at its maximum is clamped to eight.
        set_ack(64'h6867_6665_6463_6261, 4'd15);
        play_random(120);

        set_ack(64'hFFFF_FFFF_FFFF_FFFF, 4'd3);
        play_random(100);

        // A zero byte inside the pattern must be matched like any other.
        set_ack(64'h0000_0000_006B_006F, 4'd3);
        play_random(100);

        // A write to an unused index is ignored.
        settle();
        write_reg(CFG_SPARE, {$urandom, $urandom});

        set_ack({$urandom, $urandom}, 4'($urandom_range(1, 8)));
        play_random(100);

        settle();
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== at_response_stream_matcher_unit.f =====
hw/rtl/at_rsm_pkg.sv
hw/rtl/at_rsm_ack.sv
hw/rtl/at_rsm_resp.sv
hw/rtl/at_rsm_ring.sv
hw/rtl/at_response_stream_matcher_unit.sv
tb/tb_top.sv
